FILE: hdl/gwgi_pkg.sv
// Shared types, constants and tables for the 4-D grid interpolator.
package gwgi_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 14;
  localparam int IDX_W     = 8;   // holds any axis index up to 255
  localparam int POS_W     = 28;  // signed Q12.16 position, held to +-2^26
  localparam int MAG_W     = 27;  // |pos - i*2^16|
  localparam int D2_W      = 54;
  localparam int DSUM_W    = 56;
  localparam int DQ_W      = 21;
  localparam int E_W       = 23;
  localparam int W_W       = 16;
  localparam int PROD_W    = 49;
  localparam int NUM_W     = 53;
  localparam int DEN_W     = 20;
  localparam int REM_W     = 21;
  localparam int DIVD_W    = 56;
  localparam int DIV_STEPS = 4;
  localparam int DIV_ITERS = DIVD_W / DIV_STEPS;

  localparam logic [17:0]         KEXP      = 18'd133747;
  localparam logic [DQ_W-1:0]     DQ_MAX    = 21'h100000;
  localparam logic [48:0]         POS_LIMIT = 49'd67108864;
  localparam logic [DATA_W-1:0]   INV_RESET = 32'd65536;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ALPHA_MIN      = 3'd0,
    REG_P1_MIN         = 3'd1,
    REG_P2_MIN         = 3'd2,
    REG_X_MIN          = 3'd3,
    REG_ALPHA_INV_STEP = 3'd4,
    REG_P1_INV_STEP    = 3'd5,
    REG_P2_INV_STEP    = 3'd6,
    REG_X_INV_STEP     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DIFF, F_MULLO, F_MULHI, F_POS, F_BRACKET, F_SQUARE, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CORNER, B_DRAIN, B_DIV, B_OUT
  } back_state_t;

  typedef struct packed {
    logic [3:0][DATA_W-1:0] min;
    logic [3:0][DATA_W-1:0] inv;
  } cfg_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    opcode_t                      opcode;
    logic [ADDR_W-1:0]            load_address;
    logic [DATA_W-1:0]            load_value;
    logic [3:0][IDX_W-1:0]        lo;
    logic [3:0][1:0][D2_W-1:0]    d2;
  } job_t;

  typedef struct packed {
    logic busy;
    logic dividing;
  } back_stat_t;

  // 2^(-j/8) in Q1.16
  function automatic logic [16:0] pow2_tab(input logic [3:0] j);
    logic [16:0] t;
    case (j)
      4'd0:    t = 17'd65536;
      4'd1:    t = 17'd60097;
      4'd2:    t = 17'd55109;
      4'd3:    t = 17'd50535;
      4'd4:    t = 17'd46341;
      4'd5:    t = 17'd42495;
      4'd6:    t = 17'd38968;
      4'd7:    t = 17'd35734;
      default: t = 17'd32768;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/gwgi_ifs.sv
// Item and result channel interfaces.
interface gwgi_item_if;
  import gwgi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [ADDR_W-1:0]        load_address;
  logic signed [DATA_W-1:0] load_value;
  logic signed [DATA_W-1:0] alpha_coord;
  logic signed [DATA_W-1:0] p1_coord;
  logic signed [DATA_W-1:0] p2_coord;
  logic signed [DATA_W-1:0] x_coord;
  modport source (output valid, opcode, load_address, load_value, alpha_coord, p1_coord,
                  p2_coord, x_coord, input ready);
  modport sink (input valid, opcode, load_address, load_value, alpha_coord, p1_coord,
                p2_coord, x_coord, output ready);
endinterface

interface gwgi_result_if;
  import gwgi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interp_value;
  modport source (output valid, interp_value, input ready);
  modport sink (input valid, interp_value, output ready);
endinterface

FILE: hdl/gwgi_front.sv
// Front end: accepts transactions, computes per-axis bracket and squared distances.
module gwgi_front #(
  parameter int N_ALPHA = 8,
  parameter int N_P1    = 8,
  parameter int N_P2    = 8,
  parameter int N_X     = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  gwgi_pkg::cfg_t cfg,
  gwgi_item_if.sink      items,
  output gwgi_pkg::job_t job,
  output logic           job_valid,
  input  logic           job_ready
);
  import gwgi_pkg::*;

  localparam logic signed [11:0] NM1 [4] = '{12'(N_ALPHA - 1), 12'(N_P1 - 1),
                                             12'(N_P2 - 1), 12'(N_X - 1)};

  front_state_t state, state_next;
  logic [1:0]              ax;
  logic [3:0][DATA_W-1:0]  coord;
  logic                    neg;
  logic [32:0]             mag;
  logic [47:0]             plo;
  logic [48:0]             phi;
  logic signed [POS_W-1:0] pos;
  logic [IDX_W-1:0]        lo;

  logic signed [32:0]      diff;
  logic [48:0]             pmag;
  logic [POS_W-1:0]        pclamp;
  logic signed [11:0]      k;
  logic [IDX_W-1:0]        lo_next;
  logic signed [28:0]      d0, d1;
  logic [MAG_W-1:0]        m0, m1;
  logic [D2_W-1:0]         sq0, sq1;

  assign diff = $signed({coord[ax][DATA_W-1], coord[ax]})
              - $signed({cfg.min[ax][DATA_W-1], cfg.min[ax]});
  // ceiling of the magnitude for negative offsets gives floor of the signed value
  assign pmag   = phi + 49'(plo[47:16]) + 49'(neg && (plo[15:0] != 16'd0));
  assign pclamp = (pmag > POS_LIMIT) ? POS_LIMIT[POS_W-1:0] : pmag[POS_W-1:0];
  assign k      = pos[POS_W-1:16];

  always_comb begin
    if (pos[POS_W-1]) begin
      lo_next = '0;
    end else if (k >= NM1[ax]) begin
      lo_next = IDX_W'(NM1[ax] - 12'sd1);
    end else if (k == 12'sd0) begin
      lo_next = '0;
    end else if (pos[15:0] != 16'd0) begin
      lo_next = k[IDX_W-1:0];
    end else begin
      lo_next = IDX_W'(k - 12'sd1);
    end
  end

  assign d0  = $signed({pos[POS_W-1], pos}) - $signed({5'b0, lo, 16'b0});
  assign d1  = d0 - 29'sd65536;
  assign m0  = d0[28] ? MAG_W'(-d0) : d0[MAG_W-1:0];
  assign m1  = d1[28] ? MAG_W'(-d1) : d1[MAG_W-1:0];
  assign sq0 = m0 * m0;
  assign sq1 = m1 * m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = (state == F_IDLE);
    job_valid   = (state == F_PUSH);
    case (state)
      F_IDLE: begin
        if (items.valid) begin
          state_next = (opcode_t'(items.opcode) == OP_QUERY) ? F_DIFF : F_PUSH;
        end
      end
      F_DIFF:    state_next = F_MULLO;
      F_MULLO:   state_next = F_MULHI;
      F_MULHI:   state_next = F_POS;
      F_POS:     state_next = F_BRACKET;
      F_BRACKET: state_next = F_SQUARE;
      F_SQUARE:  state_next = (ax == 2'd3) ? F_PUSH : F_DIFF;
      F_PUSH: begin
        if (job_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      job.opcode       <= opcode_t'(items.opcode);
      job.load_address <= items.load_address;
      job.load_value   <= items.load_value;
      coord[0]         <= items.alpha_coord;
      coord[1]         <= items.p1_coord;
      coord[2]         <= items.p2_coord;
      coord[3]         <= items.x_coord;
      ax               <= 2'd0;
    end
    case (state)
      F_DIFF: begin
        neg <= diff[32];
        mag <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      F_MULLO:   plo <= mag[15:0] * cfg.inv[ax];
      F_MULHI:   phi <= mag[32:16] * cfg.inv[ax];
      F_POS:     pos <= neg ? -$signed(pclamp) : $signed(pclamp);
      F_BRACKET: lo <= lo_next;
      F_SQUARE: begin
        job.lo[ax]    <= lo;
        job.d2[ax][0] <= sq0;
        job.d2[ax][1] <= sq1;
        ax            <= ax + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/gwgi_queue.sv
// Two-entry queue between front and back.
module gwgi_queue (
  input  logic           clk,
  input  logic           rst,
  input  gwgi_pkg::job_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output gwgi_pkg::job_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import gwgi_pkg::*;

  job_t       slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_data;
  end

endmodule

FILE: hdl/gwgi_back.sv
// Back end: grid memory, 16-corner weighted accumulation and rounding divider.
module gwgi_back #(
  parameter int N_P1 = 8,
  parameter int N_P2 = 8,
  parameter int N_X  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gwgi_pkg::job_t         job,
  input  logic                   job_valid,
  output logic                   job_ready,
  gwgi_result_if.source          results,
  output gwgi_pkg::back_stat_t   stat
);
  import gwgi_pkg::*;

  localparam int STORE_DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  back_state_t state, state_next;
  job_t        cur;
  logic [3:0]  cnt;
  logic [4:0]  pv;
  logic [3:0]  dcnt;
  logic        pop;

  logic [8:0]          ia, ib, ic, ix;
  logic [ADDR_W-1:0]   caddr;
  logic [DSUM_W-1:0]   dsum;
  logic [DQ_W-1:0]     dq_sat;

  logic [DQ_W-1:0]          s1_dq;
  logic [DATA_W-1:0]        rd;
  logic [E_W-1:0]           s2_e;
  logic [DATA_W-1:0]        s2_v;
  logic [16:0]              s3_base;
  logic [3:0]               s3_n;
  logic                     s3_big;
  logic [DATA_W-1:0]        s3_v;
  logic [W_W-1:0]           s4_w;
  logic [DATA_W-1:0]        s4_v;
  logic signed [PROD_W-1:0] s5_prod;
  logic [W_W-1:0]           s5_w;

  logic [38:0] eprod;
  logic [16:0] t0, t1, tstep, base;
  logic [29:0] tprod;
  logic [16:0] wshift;
  logic [W_W-1:0] w_sat;

  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic [NUM_W-1:0]        nmag;
  logic                    dneg;
  logic [REM_W-1:0]        rem, rem_next;
  logic [DIVD_W-1:0]       dq, dq_next;
  logic [DATA_W-1:0]       qres;
  logic                    res_valid;
  logic [DATA_W-1:0]       res_data;

  assign pop = job_valid && job_ready;

  // corner address and summed squared distance for corner cnt
  assign ia    = 9'(cur.lo[0]) + 9'(cnt[3]);
  assign ib    = 9'(cur.lo[1]) + 9'(cnt[2]);
  assign ic    = 9'(cur.lo[2]) + 9'(cnt[1]);
  assign ix    = 9'(cur.lo[3]) + 9'(cnt[0]);
  assign caddr = ADDR_W'(((32'(ia) * 32'(N_P1) + 32'(ib)) * 32'(N_P2) + 32'(ic))
                         * 32'(N_X) + 32'(ix));
  assign dsum  = DSUM_W'(cur.d2[0][cnt[3]]) + DSUM_W'(cur.d2[1][cnt[2]])
               + DSUM_W'(cur.d2[2][cnt[1]]) + DSUM_W'(cur.d2[3][cnt[0]]);
  assign dq_sat = (dsum[DSUM_W-1:16] > 40'(DQ_MAX)) ? DQ_MAX : dsum[DQ_W+15:16];

  assign eprod = s1_dq * KEXP;

  assign t0    = pow2_tab({1'b0, s2_e[15:13]});
  assign t1    = pow2_tab(4'({1'b0, s2_e[15:13]}) + 4'd1);
  assign tstep = t0 - t1;
  assign tprod = tstep * s2_e[12:0];
  assign base  = t0 - 17'(tprod[29:13]);

  always_comb begin
    wshift = s3_base >> s3_n;
    if (s3_big) begin
      w_sat = W_W'(1);
    end else if (wshift > 17'd65535) begin
      w_sat = 16'hFFFF;
    end else if (wshift == 17'd0) begin
      w_sat = W_W'(1);
    end else begin
      w_sat = wshift[W_W-1:0];
    end
  end

  assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // four restoring steps per cycle
  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_next = {rem_next[REM_W-2:0], dq_next[DIVD_W-1]};
      dq_next  = {dq_next[DIVD_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next   = rem_next - {1'b0, den};
        dq_next[0] = 1'b1;
      end
    end
  end

  assign qres = dneg ? -dq[DATA_W-1:0] : dq[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    job_ready     = (state == B_IDLE);
    stat.busy     = (state != B_IDLE);
    stat.dividing = (state == B_DIV);
    case (state)
      B_IDLE: begin
        if (job_valid && job.opcode == OP_QUERY) state_next = B_CORNER;
      end
      B_CORNER: begin
        if (cnt == 4'd15) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        if (pv == 5'd0) state_next = B_DIV;
      end
      B_DIV: begin
        if (dcnt == 4'(DIV_ITERS - 1)) state_next = B_OUT;
      end
      B_OUT: begin
        if (!res_valid || results.ready) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && job.opcode == OP_LOAD) mem[job.load_address] <= job.load_value;
    rd <= mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      res_valid <= 1'b0;
    end else begin
      pv <= {pv[3:0], state == B_CORNER};
      if (state == B_OUT && (!res_valid || results.ready)) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
      cnt <= 4'd0;
      num <= '0;
      den <= '0;
    end
    if (state == B_CORNER) cnt <= cnt + 4'd1;

    s1_dq   <= dq_sat;
    s2_e    <= eprod[38:16];
    s2_v    <= rd;
    s3_base <= base;
    s3_n    <= s2_e[19:16];
    s3_big  <= (s2_e[22:16] >= 7'd16);
    s3_v    <= s2_v;
    s4_w    <= w_sat;
    s4_v    <= s3_v;
    s5_prod <= $signed({1'b0, s4_w}) * $signed(s4_v);
    s5_w    <= s4_w;
    if (pv[4]) begin
      num <= num + NUM_W'(s5_prod);
      den <= den + DEN_W'(s5_w);
    end

    if (state == B_DRAIN && pv == 5'd0) begin
      dneg <= num[NUM_W-1];
      dq   <= DIVD_W'(nmag) + DIVD_W'(den >> 1);
      rem  <= '0;
      dcnt <= 4'd0;
    end
    if (state == B_DIV) begin
      rem  <= rem_next;
      dq   <= dq_next;
      dcnt <= dcnt + 4'd1;
    end
    if (state == B_OUT && (!res_valid || results.ready)) res_data <= qres;
  end

  assign results.valid        = res_valid;
  assign results.interp_value = res_data;

endmodule

FILE: hdl/gaussian_weighted_4d_grid_interp.sv
// Top level: APB register file, front end, queue and back end.
// Loads (opcode 0) write one Q16.16 sample into a 16384-entry grid memory; queries
// (opcode 1) return the Gaussian-weighted mean of the 16 corners around the point.
// In the front end a query is accepted, then each axis passes through difference,
// low and high partial products (the 33x32 offset product is split in two),
// position, bracket and square states, and the job is handed off. In the back end
// it is popped, makes 16 corner reads from the single grid memory port, drains the
// weight pipeline, runs the radix-16 rounding divider and presents the result. A
// two-entry queue lets the front work on the next transaction meanwhile. Memory
// entries never loaded read back as garbage; configuration is to be written only
// while idle, a rule that the user keeps and the block itself leaves unchecked.
module gaussian_weighted_4d_grid_interp #(
  parameter int N_ALPHA = 8,
  parameter int N_P1    = 8,
  parameter int N_P2    = 8,
  parameter int N_X     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  gwgi_item_if.sink                     items,
  gwgi_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [gwgi_pkg::DATA_W-1:0]   pwdata,
  output logic [gwgi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import gwgi_pkg::*;

  cfg_t       cfg;
  job_t       f_job, b_job;
  logic       f_valid, f_ready, b_valid, b_ready;
  back_stat_t bstat;
  reg_idx_t   ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min <= '0;
      cfg.inv <= {4{INV_RESET}};
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ALPHA_MIN:      cfg.min[0] <= pwdata;
        REG_P1_MIN:         cfg.min[1] <= pwdata;
        REG_P2_MIN:         cfg.min[2] <= pwdata;
        REG_X_MIN:          cfg.min[3] <= pwdata;
        REG_ALPHA_INV_STEP: cfg.inv[0] <= pwdata;
        REG_P1_INV_STEP:    cfg.inv[1] <= pwdata;
        REG_P2_INV_STEP:    cfg.inv[2] <= pwdata;
        REG_X_INV_STEP:     cfg.inv[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ALPHA_MIN:      prdata = cfg.min[0];
      REG_P1_MIN:         prdata = cfg.min[1];
      REG_P2_MIN:         prdata = cfg.min[2];
      REG_X_MIN:          prdata = cfg.min[3];
      REG_ALPHA_INV_STEP: prdata = cfg.inv[0];
      REG_P1_INV_STEP:    prdata = cfg.inv[1];
      REG_P2_INV_STEP:    prdata = cfg.inv[2];
      REG_X_INV_STEP:     prdata = cfg.inv[3];
      default:            prdata = '0;
    endcase
  end

  gwgi_front #(
    .N_ALPHA (N_ALPHA),
    .N_P1    (N_P1),
    .N_P2    (N_P2),
    .N_X     (N_X)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .items     (items),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  gwgi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (f_job),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (b_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  gwgi_back #(
    .N_P1 (N_P1),
    .N_P2 (N_P2),
    .N_X  (N_X)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (b_job),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .results   (results),
    .stat      (bstat)
  );

`ifndef NO_ASSERTIONS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_ready) |-> !bstat.busy)
    else $error("queue popped while back end busy");

  a_load_no_work: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_ready && b_job.opcode == OP_LOAD) |=> !bstat.busy)
    else $error("load transaction started query work");

  a_div_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(bstat.dividing) |-> $past(bstat.busy))
    else $error("divider started without a query in flight");
`endif

endmodule
